// ===== hdl/tlvr_pkg.sv =====
`timescale 1ns / 1ps

package tlvr_pkg;

	localparam int unsigned POS_W = 9;

	typedef enum logic [1:0] {
		MODE_BYTE    = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_READ    = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		RSP_NONE        = 3'd0,
		RSP_ACK         = 3'd1,
		RSP_NACK        = 3'd2,
		RSP_WRONG_TYPE  = 3'd3,
		RSP_WRONG_SUM   = 3'd4
	} rsp_t;

	typedef enum logic [1:0] {
		PH_TYPE   = 2'd0,
		PH_LENGTH = 2'd1,
		PH_VALUE  = 2'd2
	} phase_t;

	localparam logic [1:0] CFG_PROG_TYPE = 2'd0;
	localparam logic [1:0] CFG_RUN_TYPE  = 2'd1;
	localparam logic [1:0] CFG_MSG_TYPE  = 2'd2;

	localparam logic [7:0] PROG_TYPE_RESET = 8'h01;
	localparam logic [7:0] RUN_TYPE_RESET  = 8'h02;
	localparam logic [7:0] MSG_TYPE_RESET  = 8'h03;

	localparam logic [7:0] ADDR_END_LEN = 8'd5;

	typedef struct packed {
		logic [7:0] prog_code;
		logic [7:0] run_code;
		logic [7:0] msg_code;
	} cfg_t;

	typedef struct packed {
		logic       we;
		logic       slot;
		logic [7:0] pos;
		logic [7:0] data;
	} wr_req_t;

	typedef struct packed {
		rsp_t        response;
		logic        frame_done;
		logic        frame_overflow;
		logic        done_slot;
		logic [31:0] frame_address;
		logic [7:0]  data_length;
		logic        enter_programming;
		logic        enter_running;
		logic [1:0]  ready_mask;
		logic        first_ready_slot;
	} result_t;

endpackage

// ===== hdl/tlvr_store.sv =====
`timescale 1ns / 1ps

module tlvr_store import tlvr_pkg::*; #(
	parameter int unsigned FRAME_BYTES = 128
) (
	input  logic       clk,
	input  wr_req_t    wr,
	input  logic       rd_en,
	input  logic       rd_slot,
	input  logic [7:0] rd_index,
	output logic [7:0] rd_data
);

	localparam int unsigned AW = $clog2(2 * FRAME_BYTES);
	localparam int unsigned PW = $clog2(FRAME_BYTES);

	logic [7:0]    mem [2 * FRAME_BYTES];
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	assign waddr = (wr.slot ? AW'(FRAME_BYTES) : '0) + AW'(wr.pos[PW-1:0]);
	assign raddr = (rd_slot ? AW'(FRAME_BYTES) : '0) + AW'(rd_index[PW-1:0]);

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[waddr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[raddr];
		end
	end

endmodule

// ===== hdl/tlvr_ctrl.sv =====
`timescale 1ns / 1ps

module tlvr_ctrl import tlvr_pkg::*; #(
	parameter int unsigned FRAME_BYTES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [1:0] mode,
	input  logic [7:0] rx_byte,
	input  logic       slot,
	input  cfg_t       cfg,
	output wr_req_t    wr,
	output result_t    res
);

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       len_q, len_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       type_q, type_d;
	logic             act_q, act_d;
	logic [1:0]       free_q, free_d;
	logic [31:0]      addr_q, addr_d;
	logic [7:0]       sum_new;
	logic             frame_end;
	logic             starts_frame;

	assign sum_new      = sum_q + rx_byte;
	assign frame_end    = pos_q >= ({1'b0, len_q} + 9'd1);
	assign starts_frame = (free_q != 2'b00) && (rx_byte != cfg.prog_code)
		&& (rx_byte != cfg.run_code);

	always_comb begin
		phase_d = phase_q;
		if (step && mode_t'(mode) == MODE_BYTE) begin
			unique case (phase_q)
				PH_TYPE: begin
					if (starts_frame) begin
						phase_d = PH_LENGTH;
					end
				end
				PH_LENGTH: phase_d = PH_VALUE;
				PH_VALUE: begin
					if (frame_end) begin
						phase_d = PH_TYPE;
					end
				end
				default: phase_d = PH_TYPE;
			endcase
		end
	end

	always_comb begin
		res    = '0;
		wr     = '0;
		pos_d  = pos_q;
		len_d  = len_q;
		sum_d  = sum_q;
		type_d = type_q;
		act_d  = act_q;
		free_d = free_q;
		addr_d = addr_q;
		if (step) begin
			unique case (mode_t'(mode)) inside
				MODE_BYTE: begin
					if (phase_q == PH_TYPE) begin
						if (free_q == 2'b00) begin
							res.response = RSP_NACK;
						end else if (rx_byte == cfg.prog_code) begin
							res.response          = RSP_ACK;
							res.enter_programming = 1'b1;
						end else if (rx_byte == cfg.run_code) begin
							res.enter_running = 1'b1;
						end else begin
							act_d   = ~free_q[0];
							wr.we   = 1'b1;
							wr.slot = ~free_q[0];
							wr.pos  = 8'd0;
							wr.data = rx_byte;
							type_d  = rx_byte;
							sum_d   = rx_byte;
							pos_d   = 9'd1;
						end
					end else begin
						wr.we   = pos_q < POS_W'(FRAME_BYTES);
						wr.slot = act_q;
						wr.pos  = pos_q[7:0];
						wr.data = rx_byte;
						sum_d   = sum_new;
						if (phase_q == PH_LENGTH) begin
							len_d = rx_byte;
							pos_d = pos_q + 9'd1;
						end else if (!frame_end) begin
							pos_d = pos_q + 9'd1;
							case (pos_q)
								9'd2: addr_d[7:0]   = rx_byte;
								9'd3: addr_d[15:8]  = rx_byte;
								9'd4: addr_d[23:16] = rx_byte;
								9'd5: addr_d[31:24] = rx_byte;
								default: addr_d = addr_q;
							endcase
						end else begin
							pos_d = '0;
							if (sum_new != 8'd0) begin
								res.response = (type_q == cfg.msg_code)
									? RSP_WRONG_SUM : RSP_WRONG_TYPE;
							end else if (pos_q >= POS_W'(FRAME_BYTES)) begin
								res.frame_overflow = 1'b1;
							end else begin
								res.frame_done = 1'b1;
								res.done_slot  = act_q;
								free_d         = free_q & ~(2'b01 << act_q);
								if (len_q >= ADDR_END_LEN) begin
									res.frame_address = addr_q;
									res.data_length   = len_q - ADDR_END_LEN;
								end
							end
						end
					end
				end
				MODE_RELEASE: free_d = free_q | (2'b01 << slot);
				MODE_READ, MODE_NOP: free_d = free_q;
				default: free_d = free_q;
			endcase
		end
		res.ready_mask       = ~free_d;
		res.first_ready_slot = free_d[0] && !free_d[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			pos_q   <= '0;
			len_q   <= '0;
			sum_q   <= '0;
			type_q  <= '0;
			act_q   <= 1'b0;
			free_q  <= 2'b11;
			addr_q  <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
			type_q  <= type_d;
			act_q   <= act_d;
			free_q  <= free_d;
			addr_q  <= addr_d;
		end
	end

endmodule

// ===== hdl/tlv_frame_receiver.sv =====
`timescale 1ns / 1ps

// Each accepted word's result word is registered and is output in the next cycle.
// Throughput: one word per cycle; the frame memory takes one write and one registered
// read per cycle, and a new word is taken in the cycle the previous result word is taken,
// so a stalled result word holds the input.
// Reset is asynchronous and active low; it clears the parser state and frees both slots.
// The frame memory is not cleared; a byte is readable once its frame has written it.

module tlv_frame_receiver import tlvr_pkg::*; #(
	parameter int unsigned FRAME_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  rx_byte,
	input  logic        slot,
	input  logic [7:0]  read_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  response,
	output logic        frame_done,
	output logic        frame_overflow,
	output logic        done_slot,
	output logic [31:0] frame_address,
	output logic [7:0]  data_length,
	output logic        enter_programming,
	output logic        enter_running,
	output logic [7:0]  read_data,
	output logic [1:0]  ready_mask,
	output logic        first_ready_slot,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t       cfg_q;
	result_t    res;
	result_t    res_s1;
	wr_req_t    wr;
	logic       accept;
	logic       rd_en;
	logic       rd_sel_s1;
	logic       out_valid_q;
	logic [7:0] rd_data;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign rd_en    = accept && mode_t'(mode) == MODE_READ
		&& {1'b0, read_index} < POS_W'(FRAME_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prog_code <= PROG_TYPE_RESET;
			cfg_q.run_code  <= RUN_TYPE_RESET;
			cfg_q.msg_code  <= MSG_TYPE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PROG_TYPE: cfg_q.prog_code <= cfg_data;
				CFG_RUN_TYPE:  cfg_q.run_code  <= cfg_data;
				CFG_MSG_TYPE:  cfg_q.msg_code  <= cfg_data;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	tlvr_ctrl #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.mode   (mode),
		.rx_byte(rx_byte),
		.slot   (slot),
		.cfg    (cfg_q),
		.wr     (wr),
		.res    (res)
	);

	tlvr_store #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_slot (slot),
		.rd_index(read_index),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1    <= res;
			rd_sel_s1 <= rd_en;
		end
	end

	assign out_valid         = out_valid_q;
	assign response          = res_s1.response;
	assign frame_done        = res_s1.frame_done;
	assign frame_overflow    = res_s1.frame_overflow;
	assign done_slot         = res_s1.done_slot;
	assign frame_address     = res_s1.frame_address;
	assign data_length       = res_s1.data_length;
	assign enter_programming = res_s1.enter_programming;
	assign enter_running     = res_s1.enter_running;
	assign read_data         = rd_sel_s1 ? rd_data : 8'd0;
	assign ready_mask        = res_s1.ready_mask;
	assign first_ready_slot  = res_s1.first_ready_slot;

endmodule

// ===== hdl/tlvr_checker.sv =====
`timescale 1ns / 1ps

module tlvr_checker import tlvr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] response,
	input logic       frame_done,
	input logic       frame_overflow,
	input logic       done_slot,
	input logic [1:0] ready_mask,
	input logic       first_ready_slot
);

	a_accept_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("accepted word produced no result word");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(response)
			&& $stable(ready_mask)))
		else $error("stalled result word changed");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |-> (!frame_overflow && response == RSP_NONE
			&& ready_mask[done_slot]))
		else $error("completed frame reported inconsistently");

	a_first_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (first_ready_slot == (!ready_mask[0] && ready_mask[1])))
		else $error("first ready slot disagrees with ready mask");

endmodule

bind tlv_frame_receiver tlvr_checker u_tlvr_checker (.*);

// ===== tb/sv/tlv_frame_checker.sv =====
`timescale 1ns / 1ps

module tlv_frame_checker import tlvr_pkg::*; #(
	parameter int FRAME_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  rx_byte,
	input  logic        slot,
	input  logic [7:0]  read_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  response,
	input  logic        frame_done,
	input  logic        frame_overflow,
	input  logic        done_slot,
	input  logic [31:0] frame_address,
	input  logic [7:0]  data_length,
	input  logic        enter_programming,
	input  logic        enter_running,
	input  logic [7:0]  read_data,
	input  logic [1:0]  ready_mask,
	input  logic        first_ready_slot,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          error_count,
	output int          words_in_flight
);

	typedef struct packed {
		rsp_t        response;
		logic        done;
		logic        overflow;
		logic        dslot;
		logic [31:0] address;
		logic [7:0]  dlen;
		logic        prog;
		logic        run;
		logic [7:0]  rdata;
		logic [1:0]  ready;
		logic        first;
	} word_result_t;

	logic [7:0] prog_code;
	logic [7:0] run_code;
	logic [7:0] msg_code;
	phase_t     rx_phase;
	logic [8:0] rx_pos;
	logic [7:0] rx_len;
	logic [7:0] rx_sum;
	logic [7:0] rx_type;
	logic       rx_slot;
	logic [1:0] free_slots;
	logic [7:0] slot_mem [0:2*FRAME_BYTES-1];

	word_result_t pending_results[$];
	word_result_t seen;
	word_result_t wanted;

	initial begin
		error_count = 0;
		words_in_flight = 0;
	end

	task automatic report_error(input string msg);
		if (error_count < 50)
			$display("%0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	function automatic word_result_t predict_word(input logic [1:0] m, input logic [7:0] b,
		input logic s, input logic [7:0] idx);
		word_result_t r;
		int base;
		r = '0;
		r.response = RSP_NONE;
		case (mode_t'(m))
			MODE_BYTE: begin
				if (rx_phase == PH_TYPE) begin
					if (free_slots == 2'b00) begin
						r.response = RSP_NACK;
					end else if (b == prog_code) begin
						r.prog = 1'b1;
						r.response = RSP_ACK;
					end else if (b == run_code) begin
						r.run = 1'b1;
					end else begin
						rx_slot = free_slots[0] ? 1'b0 : 1'b1;
						slot_mem[int'(rx_slot) * FRAME_BYTES] = b;
						rx_type = b;
						rx_sum = b;
						rx_pos = 9'd1;
						rx_phase = PH_LENGTH;
					end
				end else begin
					base = int'(rx_slot) * FRAME_BYTES;
					if (int'(rx_pos) < FRAME_BYTES)
						slot_mem[base + int'(rx_pos)] = b;
					rx_sum = rx_sum + b;
					if (rx_phase == PH_LENGTH) begin
						rx_len = b;
						rx_phase = PH_VALUE;
						rx_pos = rx_pos + 9'd1;
					end else if (int'(rx_pos) < int'(rx_len) + 1) begin
						rx_pos = rx_pos + 9'd1;
					end else begin
						if (rx_sum != 8'd0) begin
							r.response = (rx_type == msg_code) ? RSP_WRONG_SUM : RSP_WRONG_TYPE;
						end else if (int'(rx_pos) >= FRAME_BYTES) begin
							r.overflow = 1'b1;
						end else begin
							r.done = 1'b1;
							r.dslot = rx_slot;
							free_slots[rx_slot] = 1'b0;
							if (rx_len >= ADDR_END_LEN) begin
								r.address = {slot_mem[base + 5], slot_mem[base + 4],
									slot_mem[base + 3], slot_mem[base + 2]};
								r.dlen = rx_len - ADDR_END_LEN;
							end
						end
						rx_phase = PH_TYPE;
						rx_pos = '0;
					end
				end
			end
			MODE_RELEASE: begin
				free_slots[s] = 1'b1;
			end
			MODE_READ: begin
				if (int'(idx) < FRAME_BYTES)
					r.rdata = slot_mem[int'(s) * FRAME_BYTES + int'(idx)];
			end
			default: begin
			end
		endcase
		r.ready = ~free_slots;
		r.first = !r.ready[0] && r.ready[1];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_code = PROG_TYPE_RESET;
			run_code = RUN_TYPE_RESET;
			msg_code = MSG_TYPE_RESET;
			rx_phase = PH_TYPE;
			rx_pos = '0;
			rx_len = '0;
			rx_sum = '0;
			rx_type = '0;
			rx_slot = 1'b0;
			free_slots = 2'b11;
			pending_results.delete();
			words_in_flight = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_PROG_TYPE: prog_code = cfg_data;
					CFG_RUN_TYPE:  run_code = cfg_data;
					CFG_MSG_TYPE:  msg_code = cfg_data;
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_error("result word with no input word waiting for it");
				end else begin
					wanted = pending_results.pop_front();
					seen.response = rsp_t'(response);
					seen.done = frame_done;
					seen.overflow = frame_overflow;
					seen.dslot = done_slot;
					seen.address = frame_address;
					seen.dlen = data_length;
					seen.prog = enter_programming;
					seen.run = enter_running;
					seen.rdata = read_data;
					seen.ready = ready_mask;
					seen.first = first_ready_slot;
					check_field("response", 32'(seen.response), 32'(wanted.response));
					check_field("frame_done", 32'(seen.done), 32'(wanted.done));
					check_field("frame_overflow", 32'(seen.overflow), 32'(wanted.overflow));
					check_field("done_slot", 32'(seen.dslot), 32'(wanted.dslot));
					check_field("frame_address", seen.address, wanted.address);
					check_field("data_length", 32'(seen.dlen), 32'(wanted.dlen));
					check_field("enter_programming", 32'(seen.prog), 32'(wanted.prog));
					check_field("enter_running", 32'(seen.run), 32'(wanted.run));
					check_field("read_data", 32'(seen.rdata), 32'(wanted.rdata));
					check_field("ready_mask", 32'(seen.ready), 32'(wanted.ready));
					check_field("first_ready_slot", 32'(seen.first), 32'(wanted.first));
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(predict_word(mode, rx_byte, slot, read_index));
			words_in_flight = pending_results.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import tlvr_pkg::*;

	localparam int FRAME_BYTES = 128;
	localparam int CYCLE_LIMIT = 300000;
	localparam int WORDS_PER_PHASE = 160;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = MODE_NOP;
	logic [7:0]  rx_byte = 8'h00;
	logic        slot = 1'b0;
	logic [7:0]  read_index = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  response;
	logic        frame_done;
	logic        frame_overflow;
	logic        done_slot;
	logic [31:0] frame_address;
	logic [7:0]  data_length;
	logic        enter_programming;
	logic        enter_running;
	logic [7:0]  read_data;
	logic [1:0]  ready_mask;
	logic        first_ready_slot;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = CFG_PROG_TYPE;
	logic [7:0]  cfg_data = 8'h00;
	int          error_count;
	int          words_in_flight;

	int         cycle_count = 0;
	int         in_idle_pct = 0;
	int         out_stall_pct = 0;
	int         words_sent = 0;
	bit         store_filled = 1'b0;
	logic [7:0] prog_code = PROG_TYPE_RESET;
	logic [7:0] run_code = RUN_TYPE_RESET;
	logic [7:0] msg_code = MSG_TYPE_RESET;

	tlv_frame_receiver #(.FRAME_BYTES(FRAME_BYTES)) dut (.*);

	tlv_frame_checker #(.FRAME_BYTES(FRAME_BYTES)) checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tlv_frame_receiver test failed");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= out_stall_pct);

	task automatic send_word(input mode_t m, input logic [7:0] b, input logic s,
		input logic [7:0] idx);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		rx_byte <= b;
		slot <= s;
		read_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(MODE_BYTE, b, 1'($urandom), 8'($urandom));
	endtask

	task automatic consumer_access();
		int pick;
		logic [7:0] idx;
		pick = $urandom_range(9);
		idx = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(FRAME_BYTES - 1));
		if (pick < 4)
			send_word(MODE_RELEASE, 8'($urandom), 1'($urandom), 8'($urandom));
		else if (pick < 9 && store_filled)
			send_word(MODE_READ, 8'($urandom), 1'($urandom), idx);
		else
			send_word(MODE_NOP, 8'($urandom), 1'($urandom), 8'($urandom));
	endtask

	// Consumer accesses may be mixed between payload bytes; they leave the parser alone.
	task automatic send_frame(input logic [7:0] kind, input logic [7:0] len, input bit good_sum,
		input int mix_pct);
		logic [7:0] sum;
		logic [7:0] b;
		int k;
		send_byte(kind);
		sum = kind;
		send_byte(len);
		sum = sum + len;
		for (k = 1; k < int'(len); k++) begin
			if ($urandom_range(99) < mix_pct)
				consumer_access();
			b = 8'($urandom);
			send_byte(b);
			sum = sum + b;
		end
		b = -sum;
		if (!good_sum)
			b = b + 8'($urandom_range(255, 1));
		send_byte(b);
	endtask

	function automatic logic [7:0] plain_type();
		logic [7:0] t;
		do
			t = 8'($urandom);
		while (t == prog_code || t == run_code);
		return t;
	endfunction

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (words_in_flight != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic set_codes(input logic [7:0] p, input logic [7:0] r, input logic [7:0] m);
		wait_idle();
		prog_code = p;
		run_code = r;
		msg_code = m;
		cfg_write <= 1'b1;
		cfg_index <= CFG_PROG_TYPE;
		cfg_data <= p;
		@(negedge clk);
		cfg_index <= CFG_RUN_TYPE;
		cfg_data <= r;
		@(negedge clk);
		cfg_index <= CFG_MSG_TYPE;
		cfg_data <= m;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int p;
		int first_word;
		int pick;
		logic [7:0] len;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Write every byte of both slots before any read: two overlong frames
		// with a short one in between to push the second into slot 1.
		send_frame(8'h40, 8'd127, 1'b1, 0);
		send_frame(8'h41, 8'd0, 1'b1, 0);
		send_frame(8'h42, 8'd127, 1'b1, 0);
		store_filled = 1'b1;

		send_word(MODE_READ, 8'h00, 1'b0, 8'd0);
		send_word(MODE_READ, 8'hFF, 1'b1, 8'd127);
		send_word(MODE_READ, 8'h00, 1'b1, 8'd128);
		send_word(MODE_READ, 8'hFF, 1'b0, 8'd255);
		send_frame(8'hFF, 8'd5, 1'b1, 0);
		send_byte(8'h40);
		send_byte(prog_code);
		send_word(MODE_RELEASE, 8'h00, 1'b0, 8'h00);
		send_word(MODE_RELEASE, 8'hFF, 1'b0, 8'hFF);
		send_byte(prog_code);
		send_byte(run_code);
		send_frame(msg_code, 8'd4, 1'b0, 0);
		send_frame(8'h00, 8'd1, 1'b0, 0);
		send_frame(8'h00, 8'd0, 1'b1, 0);
		send_word(MODE_NOP, 8'hFF, 1'b1, 8'hFF);
		send_word(MODE_RELEASE, 8'h00, 1'b1, 8'h00);
		send_word(MODE_RELEASE, 8'h00, 1'b0, 8'h00);

		for (p = 0; p < 8; p++) begin
			case (p)
				0: set_codes(PROG_TYPE_RESET, RUN_TYPE_RESET, MSG_TYPE_RESET);
				1: set_codes(8'h00, 8'hFF, 8'h80);
				2: set_codes(8'hFF, 8'hFF, 8'h00);
				3: set_codes(8'h80, 8'h00, 8'hFF);
				default: set_codes(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			case (p % 4)
				0: begin
					in_idle_pct = 0;
					out_stall_pct = 0;
				end
				1: begin
					in_idle_pct = 48;
					out_stall_pct = 0;
				end
				2: begin
					in_idle_pct = 0;
					out_stall_pct = 48;
				end
				default: begin
					in_idle_pct = 22;
					out_stall_pct = 22;
				end
			endcase
			first_word = words_sent;
			while (words_sent - first_word < WORDS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					send_byte(8'($urandom));
				end else if (pick < 16) begin
					consumer_access();
				end else if (pick < 20) begin
					send_byte($urandom_range(1) ? prog_code : run_code);
				end else begin
					if ($urandom_range(3) != 0)
						send_word(MODE_RELEASE, 8'($urandom), 1'($urandom), 8'($urandom));
					pick = $urandom_range(99);
					if (pick < 70)
						len = 8'($urandom_range(12));
					else if (pick < 96)
						len = 8'($urandom_range(40, 13));
					else if (pick < 99)
						len = 8'($urandom_range(140, 100));
					else
						len = 8'($urandom_range(255, 240));
					send_frame(($urandom_range(2) == 0 && msg_code != prog_code
						&& msg_code != run_code) ? msg_code : plain_type(),
						len, $urandom_range(99) >= 15, 4);
				end
			end
		end

		wait_idle();
		repeat (5) @(negedge clk);
		if (error_count == 0)
			$display("tlv_frame_receiver test passed");
		else
			$display("tlv_frame_receiver test failed");
		$finish;
	end

endmodule
